>>> hdl/stt_pkg.sv
// Shared types, constants and keyword table for the source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // Source size bound; offsets saturate at POS_TOP.
    localparam longint unsigned SOURCE_BYTES = 64'd65536;
    localparam logic [15:0] POS_TOP =
        ((SOURCE_BYTES - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(SOURCE_BYTES - 64'd1);
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Identifier bytes kept for keyword matching.
    localparam int KEYWORD_CHARS = 6;
    localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
    localparam int KW_COUNT      = 13;

    // Token queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_COMMENT,
        MODE_OPER
    } t_mode;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EQ,
        OP_BANG,
        OP_LT,
        OP_GT,
        OP_SLASH
    } t_op;

    // Token kinds
    localparam logic [5:0] KIND_END     = 6'd0;
    localparam logic [5:0] KIND_NUMBER  = 6'd1;
    localparam logic [5:0] KIND_IDENT   = 6'd2;
    localparam logic [5:0] KIND_FUNC    = 6'd3;
    localparam logic [5:0] KIND_EQ_EQ   = 6'd16;
    localparam logic [5:0] KIND_NE      = 6'd17;
    localparam logic [5:0] KIND_LE      = 6'd18;
    localparam logic [5:0] KIND_GE      = 6'd19;
    localparam logic [5:0] KIND_PLUS    = 6'd20;
    localparam logic [5:0] KIND_MINUS   = 6'd21;
    localparam logic [5:0] KIND_STAR    = 6'd22;
    localparam logic [5:0] KIND_SLASH   = 6'd23;
    localparam logic [5:0] KIND_PERCENT = 6'd24;
    localparam logic [5:0] KIND_ASSIGN  = 6'd25;
    localparam logic [5:0] KIND_LT      = 6'd26;
    localparam logic [5:0] KIND_GT      = 6'd27;
    localparam logic [5:0] KIND_LPAREN  = 6'd28;
    localparam logic [5:0] KIND_RPAREN  = 6'd29;
    localparam logic [5:0] KIND_LBRACE  = 6'd30;
    localparam logic [5:0] KIND_RBRACE  = 6'd31;
    localparam logic [5:0] KIND_COMMA   = 6'd32;
    localparam logic [5:0] KIND_COLON   = 6'd33;

    // Byte codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Keyword buffer, byte 0 is the first character.
    typedef logic [KEYWORD_CHARS-1:0][7:0] t_kwbuf;

    // Keyword text written last character first, so byte 0 lands at the bottom;
    // unused bytes are zero.
    localparam t_kwbuf KW_TEXT [KW_COUNT] = '{
        t_kwbuf'("cnuf"),   t_kwbuf'("fi"),     t_kwbuf'("file"),
        t_kwbuf'("esle"),   t_kwbuf'("rof"),    t_kwbuf'("elihw"),
        t_kwbuf'("od"),     t_kwbuf'("nruter"), t_kwbuf'("tnirp"),
        t_kwbuf'("tupni"),  t_kwbuf'("labolg"), t_kwbuf'("lacol"),
        t_kwbuf'("citats")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5, 3'd2, 3'd6, 3'd5, 3'd5, 3'd6, 3'd5, 3'd6
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        ovf;
        logic        last;
    } t_token;

    // Up to two tokens pushed per source beat.
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_head;

    // Identifier or keyword kind; bytes past the run length are zero in kbuf.
    function automatic logic [5:0] kw_kind(t_kwbuf kbuf, logic [15:0] len);
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (len == 16'(KW_LEN[k]) && kbuf == KW_TEXT[k]) begin
                kind = 6'(int'(KIND_FUNC) + k);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

>>> hdl/stt_front.sv
// Front end: scanner state, byte classification and token generation.
`timescale 1ns / 1ps
`default_nettype none

module stt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_room,
    output stt_pkg::t_push     o_push
);

    function automatic logic is_space(logic [7:0] c);
        return c == stt_pkg::CH_SPACE || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= stt_pkg::CH_ZERO && c <= stt_pkg::CH_NINE;
    endfunction

    function automatic logic is_alpha_(logic [7:0] c);
        return (c >= stt_pkg::CH_LO_A && c <= stt_pkg::CH_LO_Z) ||
               (c >= stt_pkg::CH_UP_A && c <= stt_pkg::CH_UP_Z) || c == stt_pkg::CH_UNDER;
    endfunction

    stt_pkg::t_mode  r_mode, n_mode;
    stt_pkg::t_op    r_op, n_op;
    logic [15:0]     r_start, n_start;
    logic [15:0]     r_len, n_len;
    stt_pkg::t_kwbuf r_kw, n_kw;
    logic [15:0]     r_pos, n_pos;
    logic            r_ovf, n_ovf;

    logic            acc;
    logic            ovf_now;
    logic            do_flush, do_start;
    logic            fl_v, st_v;
    logic [5:0]      fl_kind, st_kind;
    logic [15:0]     fl_start, st_start, fl_len, st_len;
    stt_pkg::t_op    new_op;
    logic [5:0]      single_kind;

    assign o_stall = !i_room;
    assign acc     = i_valid && i_room;
    assign ovf_now = r_ovf || (i_ch != stt_pkg::CH_NUL && r_pos == stt_pkg::POS_TOP);

    // Operator starts and single-byte punctuation
    always_comb begin
        new_op      = stt_pkg::OP_NONE;
        single_kind = stt_pkg::KIND_END;
        case (i_ch)
            stt_pkg::CH_EQ:      new_op = stt_pkg::OP_EQ;
            stt_pkg::CH_BANG:    new_op = stt_pkg::OP_BANG;
            stt_pkg::CH_LT:      new_op = stt_pkg::OP_LT;
            stt_pkg::CH_GT:      new_op = stt_pkg::OP_GT;
            stt_pkg::CH_SLASH:   new_op = stt_pkg::OP_SLASH;
            stt_pkg::CH_PLUS:    single_kind = stt_pkg::KIND_PLUS;
            stt_pkg::CH_MINUS:   single_kind = stt_pkg::KIND_MINUS;
            stt_pkg::CH_STAR:    single_kind = stt_pkg::KIND_STAR;
            stt_pkg::CH_PERCENT: single_kind = stt_pkg::KIND_PERCENT;
            stt_pkg::CH_LPAREN:  single_kind = stt_pkg::KIND_LPAREN;
            stt_pkg::CH_RPAREN:  single_kind = stt_pkg::KIND_RPAREN;
            stt_pkg::CH_LBRACE:  single_kind = stt_pkg::KIND_LBRACE;
            stt_pkg::CH_RBRACE:  single_kind = stt_pkg::KIND_RBRACE;
            stt_pkg::CH_COMMA:   single_kind = stt_pkg::KIND_COMMA;
            stt_pkg::CH_COLON:   single_kind = stt_pkg::KIND_COLON;
            default: ;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_op     = r_op;
        n_start  = r_start;
        n_len    = r_len;
        n_kw     = r_kw;
        n_pos    = r_pos;
        n_ovf    = r_ovf;
        do_flush = 1'b0;
        do_start = 1'b0;
        fl_v     = 1'b0;
        fl_kind  = stt_pkg::KIND_END;
        fl_start = r_start;
        fl_len   = r_len;
        st_v     = 1'b0;
        st_kind  = stt_pkg::KIND_END;
        st_start = r_pos;
        st_len   = 16'd1;

        if (i_ch == stt_pkg::CH_NUL) begin
            do_flush = 1'b1;
        end else begin
            if (r_pos < stt_pkg::POS_TOP) begin
                n_pos = r_pos + 16'd1;
            end else begin
                n_ovf = 1'b1;
            end
            case (r_mode)
                stt_pkg::MODE_NUMBER: begin
                    if (is_digit(i_ch)) begin
                        if (r_len != stt_pkg::LEN_MAX) n_len = r_len + 16'd1;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                stt_pkg::MODE_IDENT: begin
                    if (is_alpha_(i_ch) || is_digit(i_ch)) begin
                        if (r_len < 16'(stt_pkg::KEYWORD_CHARS)) begin
                            n_kw[r_len[stt_pkg::KW_IDX_W-1:0]] = i_ch;
                        end
                        if (r_len != stt_pkg::LEN_MAX) n_len = r_len + 16'd1;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                stt_pkg::MODE_COMMENT: begin
                    if (i_ch == stt_pkg::CH_LF) n_mode = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_OPER: begin
                    if (r_op == stt_pkg::OP_SLASH && i_ch == stt_pkg::CH_SLASH) begin
                        n_mode = stt_pkg::MODE_COMMENT;
                        n_op   = stt_pkg::OP_NONE;
                    end else if (i_ch == stt_pkg::CH_EQ &&
                                 (r_op == stt_pkg::OP_EQ || r_op == stt_pkg::OP_BANG ||
                                  r_op == stt_pkg::OP_LT || r_op == stt_pkg::OP_GT)) begin
                        st_v     = 1'b1;
                        st_start = r_start;
                        st_len   = 16'd2;
                        case (r_op)
                            stt_pkg::OP_EQ:   st_kind = stt_pkg::KIND_EQ_EQ;
                            stt_pkg::OP_BANG: st_kind = stt_pkg::KIND_NE;
                            stt_pkg::OP_LT:   st_kind = stt_pkg::KIND_LE;
                            default:          st_kind = stt_pkg::KIND_GE;
                        endcase
                        n_mode = stt_pkg::MODE_IDLE;
                        n_op   = stt_pkg::OP_NONE;
                    end else begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default: begin
                    n_mode   = stt_pkg::MODE_IDLE;
                    do_start = 1'b1;
                end
            endcase
        end

        // Pending token out first
        if (do_flush) begin
            case (r_mode)
                stt_pkg::MODE_NUMBER: begin
                    fl_v    = 1'b1;
                    fl_kind = stt_pkg::KIND_NUMBER;
                end
                stt_pkg::MODE_IDENT: begin
                    fl_v    = 1'b1;
                    fl_kind = stt_pkg::kw_kind(r_kw, r_len);
                end
                stt_pkg::MODE_OPER: begin
                    fl_len = 16'd1;
                    case (r_op)
                        stt_pkg::OP_EQ:    begin fl_v = 1'b1; fl_kind = stt_pkg::KIND_ASSIGN; end
                        stt_pkg::OP_LT:    begin fl_v = 1'b1; fl_kind = stt_pkg::KIND_LT;     end
                        stt_pkg::OP_GT:    begin fl_v = 1'b1; fl_kind = stt_pkg::KIND_GT;     end
                        stt_pkg::OP_SLASH: begin fl_v = 1'b1; fl_kind = stt_pkg::KIND_SLASH;  end
                        default: ; // lone bang gives nothing
                    endcase
                end
                default: ;
            endcase
            n_mode = stt_pkg::MODE_IDLE;
            n_op   = stt_pkg::OP_NONE;
        end

        // New token from this byte
        if (do_start && !is_space(i_ch)) begin
            if (is_digit(i_ch)) begin
                n_mode  = stt_pkg::MODE_NUMBER;
                n_start = r_pos;
                n_len   = 16'd1;
            end else if (is_alpha_(i_ch)) begin
                n_mode  = stt_pkg::MODE_IDENT;
                n_start = r_pos;
                n_len   = 16'd1;
                n_kw    = '0;
                n_kw[0] = i_ch;
            end else if (new_op != stt_pkg::OP_NONE) begin
                n_mode  = stt_pkg::MODE_OPER;
                n_op    = new_op;
                n_start = r_pos;
                n_len   = 16'd1;
            end else if (single_kind != stt_pkg::KIND_END) begin
                st_v    = 1'b1;
                st_kind = single_kind;
            end
        end

        // End of source: END token, then back to reset values
        if (i_ch == stt_pkg::CH_NUL) begin
            st_v     = 1'b1;
            st_kind  = stt_pkg::KIND_END;
            st_start = r_pos;
            st_len   = 16'd0;
            n_mode   = stt_pkg::MODE_IDLE;
            n_op     = stt_pkg::OP_NONE;
            n_start  = 16'd0;
            n_len    = 16'd0;
            n_kw     = '0;
            n_pos    = 16'd0;
            n_ovf    = 1'b0;
        end
    end

    // Pack the beat's tokens in order
    always_comb begin
        o_push = '0;
        if (acc) begin
            o_push.count = 2'(fl_v) + 2'(st_v);
            if (fl_v) begin
                o_push.tok0 = '{kind: fl_kind, start: fl_start, len: fl_len,
                                ovf: ovf_now, last: !st_v};
                o_push.tok1 = '{kind: st_kind, start: st_start, len: st_len,
                                ovf: ovf_now, last: 1'b1};
            end else begin
                o_push.tok0 = '{kind: st_kind, start: st_start, len: st_len,
                                ovf: ovf_now, last: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= stt_pkg::MODE_IDLE;
            r_op    <= stt_pkg::OP_NONE;
            r_start <= 16'd0;
            r_len   <= 16'd0;
            r_kw    <= '0;
            r_pos   <= 16'd0;
            r_ovf   <= 1'b0;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_start <= n_start;
            r_len   <= n_len;
            r_kw    <= n_kw;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

>>> hdl/stt_queue.sv
// Token queue: two pushes, one pop per cycle.
`timescale 1ns / 1ps
`default_nettype none

module stt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  stt_pkg::t_push     i_push,
    output logic               o_room,
    output stt_pkg::t_head     o_head,
    input  wire logic          i_pop
);

    stt_pkg::t_token               r_mem [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_W-1:0]    r_wr, n_wr;
    logic [stt_pkg::QPTR_W-1:0]    r_rd, n_rd;
    logic [stt_pkg::QCNT_W-1:0]    r_cnt, n_cnt;
    logic [stt_pkg::QPTR_W-1:0]    wr_next;

    assign wr_next = r_wr + stt_pkg::QPTR_W'(1);
    // Front may only take a beat when both of its possible tokens fit.
    assign o_room  = r_cnt <= stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH - 2);
    assign o_head  = '{valid: r_cnt != '0, tok: r_mem[r_rd]};

    always_comb begin
        n_wr  = r_wr + stt_pkg::QPTR_W'(i_push.count);
        n_rd  = i_pop ? r_rd + stt_pkg::QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + stt_pkg::QCNT_W'(i_push.count) - stt_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr]    <= i_push.tok0;
        if (i_push.count == 2'd2) r_mem[wr_next] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/stt_back.sv
// Back end: output register, one token per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module stt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  stt_pkg::t_head     i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [5:0]         o_token_kind,
    output logic [15:0]        o_start_offset,
    output logic [15:0]        o_token_length,
    output logic               o_position_overflow,
    output logic               o_last
);

    logic            r_valid, n_valid;
    stt_pkg::t_token r_tok;

    assign o_pop   = i_head.valid && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_tok <= i_head.tok;
    end

    assign o_valid             = r_valid;
    assign o_token_kind        = r_tok.kind;
    assign o_start_offset      = r_tok.start;
    assign o_token_length      = r_tok.len;
    assign o_position_overflow = r_tok.ovf;
    assign o_last              = r_tok.last;

endmodule

`default_nettype wire

>>> hdl/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  source   | in        | i_valid / o_stall  | i_ch
//  token    | out       | o_valid / i_stall  | o_token_kind, o_start_offset,
//           |           |                    | o_token_length, o_position_overflow, o_last
//
// One source beat is taken per cycle unless stalled; it yields zero, one or two token beats.
// A token is written into the token queue when its source beat is taken and is later
// popped into the output register; the second token of a beat follows the first.
// Token beats leave at one per cycle unless i_stall is high; the source side stalls while the
// four-entry token queue has fewer than two free slots.
// Reset is synchronous, active low, and clears scanner state, queue and output valid.
// A token-side stall holds the output register; the queue takes beats while it has room.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_token_kind,
    output logic [15:0]      o_start_offset,
    output logic [15:0]      o_token_length,
    output logic             o_position_overflow,
    output logic             o_last
);

    stt_pkg::t_push push;  // tokens from the scanner this cycle
    stt_pkg::t_head head;  // oldest queued token
    logic           room;
    logic           pop;

    // Scanner: mode, pending operator, keyword buffer and position counter
    stt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_ch    (i_ch),
        .i_room  (room),
        .o_push  (push)
    );

    // Decouples the scanner from output stalls
    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Output register
    stt_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_token_kind        (o_token_kind),
        .o_start_offset      (o_start_offset),
        .o_token_length      (o_token_length),
        .o_position_overflow (o_position_overflow),
        .o_last              (o_last)
    );

endmodule

`default_nettype wire

>>> hdl/stt_checker.sv
// Port-level checks on the tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stt_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [5:0]  o_token_kind,
    input  wire logic [15:0] o_start_offset,
    input  wire logic [15:0] o_token_length,
    input  wire logic        o_position_overflow,
    input  wire logic        o_last
);

    // Stalled token beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
        $stable(o_start_offset) && $stable(o_token_length) &&
        $stable(o_position_overflow) && $stable(o_last))
        else $error("token beat changed under stall");

    // END closes its source beat and has no length
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == stt_pkg::KIND_END |-> o_last && o_token_length == 16'd0)
        else $error("END token malformed");

    // Every other token has a lexeme
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != stt_pkg::KIND_END |-> o_token_length != 16'd0)
        else $error("empty non-END token");

    // Two-byte comparisons
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == stt_pkg::KIND_EQ_EQ || o_token_kind == stt_pkg::KIND_NE ||
                    o_token_kind == stt_pkg::KIND_LE || o_token_kind == stt_pkg::KIND_GE)
        |-> o_token_length == 16'd2)
        else $error("comparison token length wrong");

    // Single-byte operators and punctuation
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind >= stt_pkg::KIND_PLUS |->
        o_token_length == 16'd1 && o_token_kind <= stt_pkg::KIND_COLON)
        else $error("single operator token wrong");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire

>>> bench/tb_token_checker.sv
// Token stream checker: mirrors the lexer per source beat and compares every token beat.
`timescale 1ns / 1ps

module tb_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_src_valid,
    input  logic        i_src_stall,
    input  logic [7:0]  i_src_ch,
    input  logic        i_tok_valid,
    input  logic        i_tok_stall,
    input  logic [5:0]  i_tok_kind,
    input  logic [15:0] i_tok_start,
    input  logic [15:0] i_tok_len,
    input  logic        i_tok_ovf,
    input  logic        i_tok_last,
    output int          o_mismatches,
    output int          o_tokens_due
);
    import stt_pkg::*;

    // Keyword order gives the kind: first entry is KIND_FUNC.
    string kw_names [KW_COUNT] = '{"func", "if", "elif", "else", "for", "while", "do",
                                   "return", "print", "input", "global", "local", "static"};

    t_mode       scan_mode;
    t_op         pend_op;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] src_pos;
    logic [7:0]  kw_buf [KEYWORD_CHARS];
    logic        ovf_seen;
    t_token      tokens_due [$];
    int          mismatches = 0;

    function automatic void clear_scanner();
        scan_mode = MODE_IDLE;
        pend_op   = OP_NONE;
        tok_start = '0;
        tok_len   = '0;
        src_pos   = '0;
        ovf_seen  = 1'b0;
        for (int i = 0; i < KEYWORD_CHARS; i++) kw_buf[i] = '0;
    endfunction

    function automatic void emit_token(logic [5:0] kind, logic [15:0] start, logic [15:0] len);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.ovf   = ovf_seen;
        t.last  = 1'b0;
        tokens_due.push_back(t);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic logic [5:0] word_kind();
        logic [5:0] k;
        logic       hit;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (tok_len == 16'(kw_names[i].len())) && (kw_names[i].len() <= KEYWORD_CHARS);
            for (int j = 0; j < kw_names[i].len() && j < KEYWORD_CHARS; j++) begin
                if (kw_buf[j] != kw_names[i][j]) hit = 1'b0;
            end
            if (hit && k == KIND_IDENT) k = 6'(KIND_FUNC + i);
        end
        return k;
    endfunction

    // Kind of a pending operator left on its own; a lone bang gives none.
    function automatic logic [5:0] single_kind(t_op op);
        case (op)
            OP_EQ:    return KIND_ASSIGN;
            OP_LT:    return KIND_LT;
            OP_GT:    return KIND_GT;
            OP_SLASH: return KIND_SLASH;
            default:  return KIND_END;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(t_op op);
        case (op)
            OP_EQ:   return KIND_EQ_EQ;
            OP_BANG: return KIND_NE;
            OP_LT:   return KIND_LE;
            default: return KIND_GE;
        endcase
    endfunction

    function automatic void flush_token();
        logic [5:0] k;
        case (scan_mode)
            MODE_NUMBER: emit_token(KIND_NUMBER, tok_start, tok_len);
            MODE_IDENT:  emit_token(word_kind(), tok_start, tok_len);
            MODE_OPER: begin
                k = single_kind(pend_op);
                if (k != KIND_END) emit_token(k, tok_start, 16'd1);
            end
            default: ;
        endcase
        scan_mode = MODE_IDLE;
        pend_op   = OP_NONE;
    endfunction

    function automatic void begin_token(logic [7:0] c, logic [15:0] off);
        t_op        op;
        logic [5:0] k;
        op = OP_NONE;
        k  = KIND_END;
        if (is_space(c)) return;
        if (is_digit(c)) begin
            scan_mode = MODE_NUMBER;
            tok_start = off;
            tok_len   = 16'd1;
            return;
        end
        if (is_alpha(c) || c == CH_UNDER) begin
            scan_mode = MODE_IDENT;
            tok_start = off;
            tok_len   = 16'd1;
            for (int i = 0; i < KEYWORD_CHARS; i++) kw_buf[i] = '0;
            kw_buf[0] = c;
            return;
        end
        case (c)
            CH_EQ:      op = OP_EQ;
            CH_BANG:    op = OP_BANG;
            CH_LT:      op = OP_LT;
            CH_GT:      op = OP_GT;
            CH_SLASH:   op = OP_SLASH;
            CH_PLUS:    k  = KIND_PLUS;
            CH_MINUS:   k  = KIND_MINUS;
            CH_STAR:    k  = KIND_STAR;
            CH_PERCENT: k  = KIND_PERCENT;
            CH_LPAREN:  k  = KIND_LPAREN;
            CH_RPAREN:  k  = KIND_RPAREN;
            CH_LBRACE:  k  = KIND_LBRACE;
            CH_RBRACE:  k  = KIND_RBRACE;
            CH_COMMA:   k  = KIND_COMMA;
            CH_COLON:   k  = KIND_COLON;
            default: ;
        endcase
        if (op != OP_NONE) begin
            scan_mode = MODE_OPER;
            pend_op   = op;
            tok_start = off;
            tok_len   = 16'd1;
        end else if (k != KIND_END) begin
            emit_token(k, off, 16'd1);
        end
    endfunction

    // Tokens caused by one source byte, appended to tokens_due.
    function automatic void lex_byte(logic [7:0] c);
        logic [15:0] off;
        int          n_before;
        off      = src_pos;
        n_before = tokens_due.size();
        if (c == CH_NUL) begin
            flush_token();
            emit_token(KIND_END, off, 16'd0);
            clear_scanner();
        end else begin
            if (src_pos < POS_TOP) src_pos = src_pos + 16'd1;
            else ovf_seen = 1'b1;
            case (scan_mode)
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        if (tok_len < LEN_MAX) tok_len = tok_len + 16'd1;
                    end else begin
                        flush_token();
                        begin_token(c, off);
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                        if (tok_len < KEYWORD_CHARS) kw_buf[tok_len] = c;
                        if (tok_len < LEN_MAX) tok_len = tok_len + 16'd1;
                    end else begin
                        flush_token();
                        begin_token(c, off);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) scan_mode = MODE_IDLE;
                end
                MODE_OPER: begin
                    if (pend_op == OP_SLASH && c == CH_SLASH) begin
                        scan_mode = MODE_COMMENT;
                        pend_op   = OP_NONE;
                    end else if (c == CH_EQ && pend_op inside {OP_EQ, OP_BANG, OP_LT, OP_GT}) begin
                        emit_token(pair_kind(pend_op), tok_start, 16'd2);
                        scan_mode = MODE_IDLE;
                        pend_op   = OP_NONE;
                    end else begin
                        flush_token();
                        begin_token(c, off);
                    end
                end
                default: begin
                    scan_mode = MODE_IDLE;
                    begin_token(c, off);
                end
            endcase
        end
        if (tokens_due.size() > n_before) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            clear_scanner();
            tokens_due.delete();
        end else begin
            // prediction first, so a beat accepted on this edge is already queued
            if (i_src_valid && !i_src_stall) lex_byte(i_src_ch);
            if (i_tok_valid && !i_tok_stall) begin
                if (tokens_due.size() == 0) begin
                    $error("token beat with nothing due: kind %0d, start %0d",
                           i_tok_kind, i_tok_start);
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.kind, i_tok_kind);
                    check_field("start_offset", want.start, i_tok_start);
                    check_field("token_length", want.len, i_tok_len);
                    check_field("position_overflow", want.ovf, i_tok_ovf);
                    check_field("last", want.last, i_tok_last);
                end
            end
        end
        o_mismatches <= mismatches;
        o_tokens_due <= tokens_due.size();
    end

endmodule

>>> bench/tb_source_text_tokenizer.sv
// Testbench top for the source text tokenizer: byte stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_BYTES = 440;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_ch    = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_token_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_token_length;
    logic        o_position_overflow;
    logic        o_last;

    int          mismatches;
    int          tokens_due;
    int          cycles      = 0;
    int          burst_left  = 0;
    int          sent_random = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_span  = 0;
    logic [7:0]  src_text [$];

    string kw_words [KW_COUNT] = '{"func", "if", "elif", "else", "for", "while", "do",
                                   "return", "print", "input", "global", "local", "static"};
    // Operators, punctuation, two-byte comparisons and the lone bang.
    string op_words [19] = '{"+", "-", "*", "/", "%", "=", "<", ">", "(", ")", "{", "}",
                             ",", ":", "==", "!=", "<=", ">=", "!"};

    source_text_tokenizer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_ch               (i_ch),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_token_kind       (o_token_kind),
        .o_start_offset     (o_start_offset),
        .o_token_length     (o_token_length),
        .o_position_overflow(o_position_overflow),
        .o_last             (o_last)
    );

    tb_token_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_valid (i_valid),
        .i_src_stall (o_stall),
        .i_src_ch    (i_ch),
        .i_tok_valid (o_valid),
        .i_tok_stall (i_stall),
        .i_tok_kind  (o_token_kind),
        .i_tok_start (o_start_offset),
        .i_tok_len   (o_token_length),
        .i_tok_ovf   (o_position_overflow),
        .i_tok_last  (o_last),
        .o_mismatches(mismatches),
        .o_tokens_due(tokens_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure: a randomly chosen stall style held for a random span,
    // including spells of none at all and a steady on/off pattern.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_span <= $urandom_range(16, 160);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= ~i_stall;
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // One source beat. Valid stays high straight into the next beat unless the
    // burst has run out and a gap is drawn; the gap length never looks at o_stall.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_valid <= 1'b1;
        i_ch    <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_ch    <= 8'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic play_source();
        foreach (src_text[i]) send_byte(src_text[i]);
        src_text.delete();
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        if (r < 26) return 8'(CH_LO_A + r);
        return 8'(CH_UP_A + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52) return rand_letter();
        if (r < 62) return 8'(CH_ZERO + r - 52);
        return CH_UNDER;
    endfunction

    function automatic void add_space();
        int r;
        repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(0, 5);
            src_text.push_back(r == 5 ? CH_SPACE : 8'(CH_TAB + r));
        end
    endfunction

    // Keywords, plus near misses: one byte too many, one too few, or a changed last byte.
    function automatic void add_keyword();
        string w;
        int    style;
        w     = kw_words[$urandom_range(0, KW_COUNT - 1)];
        style = $urandom_range(0, 5);
        if (style == 5) begin
            for (int i = 0; i < w.len() - 1; i++) src_text.push_back(w[i]);
            if (w.len() == 2) src_text.push_back(CH_UP_A);
        end else begin
            add_text(w);
            if (style == 4) src_text.push_back(rand_word_char());
        end
    endfunction

    // Mostly short names; now and then one past the keyword buffer.
    function automatic void add_ident();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        src_text.push_back(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_letter());
        repeat (n - 1) src_text.push_back(rand_word_char());
    endfunction

    function automatic void add_number();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        repeat (n) src_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // Line comment with arbitrary body; at the end of a source it may run into the zero byte.
    function automatic void add_comment(logic at_end);
        logic [7:0] b;
        add_text("//");
        repeat ($urandom_range(0, 16)) begin
            b = 8'($urandom_range(1, 255));
            src_text.push_back(b == CH_LF ? CH_SPACE : b);
        end
        if (!at_end || $urandom_range(0, 1) == 1) src_text.push_back(CH_LF);
    endfunction

    // Plausible program text with random content, with some noise bytes mixed in.
    function automatic void build_random_source();
        int pieces;
        int pick;
        pieces = $urandom_range(1, 14);
        for (int p = 0; p < pieces; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) add_keyword();
            else if (pick < 38) add_ident();
            else if (pick < 52) add_number();
            else if (pick < 72) add_text(op_words[$urandom_range(0, 18)]);
            else if (pick < 82) add_comment(p == pieces - 1);
            else if (pick < 90) src_text.push_back(8'($urandom_range(1, 255)));
            else add_space();
            if ($urandom_range(0, 9) < 6) add_space();
        end
        src_text.push_back(CH_NUL);
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identifier over the whole word set, lone bang, both comparisons
        // back to back, a comment holding a high byte, an operator flushed by
        // end of source, an empty source and a number flushed by end of source.
        add_text("Az_9 !x<=>= 5/ //");
        src_text.push_back(8'hFF);
        add_text("\n=");
        src_text.push_back(CH_NUL);
        src_text.push_back(CH_NUL);
        add_text("9");
        src_text.push_back(CH_NUL);
        play_source();

        while (sent_random < RANDOM_BYTES) begin
            build_random_source();
            sent_random += src_text.size();
            play_source();
        end

        // A comparison and a number in one source, then a fresh source of one punctuation byte.
        add_text("==7");
        src_text.push_back(CH_NUL);
        add_text("(");
        src_text.push_back(CH_NUL);
        play_source();
        i_valid <= 1'b0;

        // Let the checker counts settle past the last accepted beat, then drain.
        @(posedge i_clk);
        while (tokens_due != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer.sv
hdl/stt_checker.sv
bench/tb_token_checker.sv
bench/tb_source_text_tokenizer.sv
